// File: sv/mfd_pkg.sv
// Package for the Manchester frame decoder.
// Holds frame constants, field widths and the input item type; no dependencies.
package mfd_pkg;

    localparam int unsigned FRAME_BYTES = 10;
    localparam int unsigned POS_W       = 4;
    localparam int unsigned WORD_W      = 37;
    localparam int unsigned PREFIX_W    = 3;
    localparam int unsigned ADDR_W      = 24;
    localparam int unsigned PRESS_W     = 10;
    localparam int unsigned M_TDATA_W   = 40;

    localparam logic [POS_W-1:0] POS_IDLE  = POS_W'(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_FIRST = '0;
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       frame_start;
    } item_t;

endpackage

// File: sv/mfd_in_stage.sv
// Input register stage of the Manchester frame decoder.
// Depends on mfd_pkg; feeds mfd_frame_core.
module mfd_in_stage
    import mfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // raw_byte
    input  logic       s_tuser,   // frame_start
    output logic       item_valid,
    output item_t      item,
    input  logic       item_take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign s_tready   = !valid_reg || item_take;
    assign accept     = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.raw_byte    <= s_tdata;
            item_reg.frame_start <= s_tuser;
        end
    end

endmodule

// File: sv/mfd_frame_core.sv
// Pair decode, frame state and result register of the Manchester frame decoder.
// Depends on mfd_pkg; takes items from mfd_in_stage.
module mfd_frame_core
    import mfd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  item_t                item,
    output logic                 item_take,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // prefix_bits, sender_address, pressure_raw
    output logic                 m_tuser    // coding_error
);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              carry_reg, carry_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              err_reg, err_next;
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] res_word_reg;
    logic              res_err_reg;

    logic [POS_W-1:0]  pos_eff;
    logic              carry_eff;
    logic [WORD_W-1:0] word_eff;
    logic              err_eff;
    logic              active;
    logic              emit;
    logic [7:0]        b;
    logic [3:0]        d;
    logic [3:0]        e;

    assign b = item.raw_byte;

    assign pos_eff   = item.frame_start ? POS_FIRST : pos_reg;
    assign carry_eff = item.frame_start ? 1'b0 : carry_reg;
    assign word_eff  = item.frame_start ? '0 : word_reg;
    assign err_eff   = item.frame_start ? 1'b0 : err_reg;
    assign active    = item.frame_start || (pos_reg < POS_IDLE);
    assign emit      = item_valid && active && (pos_eff == POS_LAST);
    assign item_take = item_valid && (!emit || !m_valid_reg || m_tready);

    assign d[3] = carry_eff & ~b[7];
    assign e[3] = carry_eff == b[7];
    assign d[2] = b[6] & ~b[5];
    assign e[2] = b[6] == b[5];
    assign d[1] = b[4] & ~b[3];
    assign e[1] = b[4] == b[3];
    assign d[0] = b[2] & ~b[1];
    assign e[0] = b[2] == b[1];

    always_comb begin
        pos_next   = pos_reg;
        carry_next = carry_reg;
        word_next  = word_reg;
        err_next   = err_reg;
        if (item_take && active) begin
            carry_next = b[0];
            if (pos_eff == POS_FIRST) begin
                word_next = {word_eff[WORD_W-4:0], d[2:0]};
                err_next  = err_eff | (|e[2:0]);
                pos_next  = pos_eff + POS_W'(1);
            end else if (pos_eff == POS_LAST) begin
                word_next = {word_eff[WORD_W-3:0], d[3:2]};
                err_next  = err_eff | (|e[3:2]);
                pos_next  = POS_IDLE;
            end else begin
                word_next = {word_eff[WORD_W-5:0], d};
                err_next  = err_eff | (|e);
                pos_next  = pos_eff + POS_W'(1);
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (item_take && emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= POS_IDLE;
            carry_reg   <= 1'b0;
            word_reg    <= '0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            carry_reg   <= carry_next;
            word_reg    <= word_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take && emit) begin
            res_word_reg <= word_next;
            res_err_reg  <= err_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_err_reg;
    assign m_tdata  = {
        {(M_TDATA_W - WORD_W){1'b0}},
        res_word_reg[PRESS_W-1:0],
        res_word_reg[PRESS_W+ADDR_W-1:PRESS_W],
        res_word_reg[WORD_W-1:PRESS_W+ADDR_W]
    };

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_IDLE)
        else $error("byte position out of range");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_take && emit) |-> (!m_valid_reg || m_tready))
        else $error("result overwritten while held");

    a_idle_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_take && emit) |=> (pos_reg == POS_IDLE) && m_tvalid)
        else $error("frame not closed after last byte");

    a_start_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_take && item.frame_start) |=> (pos_reg == POS_W'(1)))
        else $error("frame start did not advance position");

endmodule

// File: sv/manchester_frame_decoder.sv
// Manchester frame decoder top level: one raw frame byte per request in,
// one decoded frame result per ten-byte frame out. Depends on mfd_pkg.
// Throughput: one byte per cycle, set by the single-pass pair decode, unless a
// held result waits on m_tready. The tenth byte of a frame passes the input
// register, then its decoded result is registered in the result register.
// Reset (aresetn low, synchronous) empties both registers and idles the frame.
module manchester_frame_decoder
    import mfd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // raw_byte
    input  logic                 s_tuser,   // frame_start
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // prefix_bits, sender_address, pressure_raw
    output logic                 m_tuser    // coding_error
);

    logic  item_valid;
    item_t item;
    logic  item_take;

    mfd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    mfd_frame_core u_frame_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

// File: tb/tb_manchester_frame_decoder.sv
// Self-checking testbench for manchester_frame_decoder: streams raw frame bytes,
// predicts each decoded frame result and compares it field by field.
// Depends on mfd_pkg and manchester_frame_decoder.
module tb_manchester_frame_decoder;
    import mfd_pkg::*;

    localparam int unsigned LAST_PAIR_BIT = 74;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned HOLD_AT_FRAME = 30;

    typedef struct packed {
        logic [PREFIX_W-1:0] prefix_bits;
        logic [ADDR_W-1:0]   sender_address;
        logic [PRESS_W-1:0]  pressure_raw;
        logic                coding_error;
    } frame_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = '0;   // raw_byte
    logic                 s_tuser  = 1'b0; // frame_start
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // prefix_bits, sender_address, pressure_raw
    logic                 m_tuser;         // coding_error

    item_t         byte_requests[$];
    frame_result_t expected_frames[$];

    logic [POS_W-1:0]  frame_pos    = POS_IDLE;
    logic              half_bit     = 1'b0;
    logic [WORD_W-1:0] frame_word   = '0;
    logic              pair_invalid = 1'b0;

    bit quiet = 1'b0;
    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned frames_seen    = 0;
    int unsigned send_gap       = 0;
    int unsigned send_idle_pct  = 10;
    int unsigned recv_gap       = 0;
    int unsigned recv_idle_pct  = 10;
    int unsigned hold_count     = 0;
    bit          hold_done      = 1'b0;

    manchester_frame_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    task automatic decode_frame_byte(input logic [7:0] raw, input logic start);
        int unsigned   bit_idx;
        logic          cur;
        frame_result_t res;
        if (start) begin
            frame_pos    = POS_FIRST;
            half_bit     = 1'b0;
            frame_word   = '0;
            pair_invalid = 1'b0;
        end
        if (frame_pos < POS_IDLE) begin
            for (int k = 0; k < 8; k++) begin
                bit_idx = frame_pos * 8 + k;
                cur     = raw[7-k];
                if (bit_idx == 0 || bit_idx > LAST_PAIR_BIT)
                    continue;
                if (bit_idx[0]) begin
                    half_bit = cur;
                end else begin
                    if (half_bit == cur)
                        pair_invalid = 1'b1;
                    frame_word = {frame_word[WORD_W-2:0], half_bit & ~cur};
                end
            end
            if (frame_pos == POS_LAST) begin
                frame_pos          = POS_IDLE;
                res.prefix_bits    = frame_word[36:34];
                res.sender_address = frame_word[33:10];
                res.pressure_raw   = frame_word[9:0];
                res.coding_error   = pair_invalid;
                expected_frames.push_back(res);
            end else begin
                frame_pos = frame_pos + 1'b1;
            end
        end
    endtask

    // Encode a word into a frame and queue n_bytes requests; bytes past the
    // tenth are trailing noise without a frame start.
    task automatic queue_frame(input logic [WORD_W-1:0] word, input int bad_pair,
                               input int unsigned n_bytes);
        logic [79:0] air;
        logic        stuck;
        item_t       req;
        air = 80'({$urandom(), $urandom(), $urandom()});
        for (int i = 0; i < WORD_W; i++) begin
            air[79-(2*i+1)] = word[WORD_W-1-i];
            air[79-(2*i+2)] = ~word[WORD_W-1-i];
            if (i == bad_pair) begin
                stuck = 1'($urandom_range(0, 1));
                air[79-(2*i+1)] = stuck;
                air[79-(2*i+2)] = stuck;
            end
        end
        for (int j = 0; j < n_bytes; j++) begin
            req.frame_start = (j == 0);
            req.raw_byte    = (j < FRAME_BYTES) ? air[79-8*j -: 8] : 8'($urandom());
            byte_requests.push_back(req);
        end
    endtask

    task automatic queue_random_traffic(input int unsigned n_items);
        int unsigned       queued;
        int unsigned       pick;
        int unsigned       n;
        logic [WORD_W-1:0] word;
        item_t             req;
        queued = 0;
        while (queued < n_items) begin
            pick = $urandom_range(0, 99);
            word = WORD_W'({$urandom(), $urandom()});
            if (pick < 70) begin
                n = ($urandom_range(0, 9) == 0) ? FRAME_BYTES + $urandom_range(1, 3)
                                                : FRAME_BYTES;
                queue_frame(word, ($urandom_range(0, 6) == 0) ? $urandom_range(0, 36) : -1,
                            n);
            end else if (pick < 80) begin
                n = $urandom_range(1, FRAME_BYTES - 1);
                queue_frame(word, -1, n);
            end else if (pick < 90) begin
                n = $urandom_range(1, 3);
                for (int j = 0; j < n; j++) begin
                    req.raw_byte    = 8'($urandom());
                    req.frame_start = 1'b0;
                    byte_requests.push_back(req);
                end
            end else begin
                n    = FRAME_BYTES;
                word = $urandom_range(0, 1) ? '1 : '0;
                queue_frame(word, ($urandom_range(0, 1) == 0) ? 36 : -1, n);
            end
            queued += n;
        end
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (byte_requests.size() != 0 || s_tvalid || expected_frames.size() != 0);
    endtask

    always @(posedge aclk) begin : driver
        item_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                decode_frame_byte(s_tdata, s_tuser);
            if (cycle_count % 128 == 0)
                send_idle_pct = quiet ? 0 : ($urandom_range(0, 2) * 12);
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (byte_requests.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
                send_gap = $urandom_range(0, 6);
                s_tvalid <= 1'b0;
            end else begin
                req = byte_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= req.raw_byte;
                s_tuser  <= req.frame_start;
            end
        end
    end

    always @(posedge aclk) begin : monitor
        frame_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                frames_seen++;
                if (expected_frames.size() == 0) begin
                    $error("unexpected result: tdata=%h tuser=%b", m_tdata, m_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_frames.pop_front();
                    if (m_tdata[2:0] !== want.prefix_bits) begin
                        $error("prefix_bits: expected %h, actual %h",
                               want.prefix_bits, m_tdata[2:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[26:3] !== want.sender_address) begin
                        $error("sender_address: expected %h, actual %h",
                               want.sender_address, m_tdata[26:3]);
                        mismatch_count++;
                    end
                    if (m_tdata[36:27] !== want.pressure_raw) begin
                        $error("pressure_raw: expected %h, actual %h",
                               want.pressure_raw, m_tdata[36:27]);
                        mismatch_count++;
                    end
                    if (m_tuser !== want.coding_error) begin
                        $error("coding_error: expected %b, actual %b",
                               want.coding_error, m_tuser);
                        mismatch_count++;
                    end
                end
                if (frames_seen == HOLD_AT_FRAME && !hold_done) begin
                    hold_count = LONG_HOLD;
                    hold_done  = 1'b1;
                end
            end
            if (cycle_count % 128 == 64)
                recv_idle_pct = quiet ? 0 : ($urandom_range(0, 2) * 12);
            if (hold_count > 0) begin
                hold_count--;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < recv_idle_pct) begin
                recv_gap = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_manchester_frame_decoder: FAIL");
            $finish;
        end
    end

    initial begin
        item_t req;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // idle bytes, then an aborted frame with bad pairs that a new start discards
        req.frame_start = 1'b0; req.raw_byte = 8'h00; byte_requests.push_back(req);
        req.frame_start = 1'b0; req.raw_byte = 8'hFF; byte_requests.push_back(req);
        req.frame_start = 1'b1; req.raw_byte = 8'hFF; byte_requests.push_back(req);
        req.frame_start = 1'b0; req.raw_byte = 8'h00; byte_requests.push_back(req);
        req.frame_start = 1'b0; req.raw_byte = 8'hFF; byte_requests.push_back(req);
        queue_frame('1, -1, FRAME_BYTES + 1);
        queue_frame('0, 3, FRAME_BYTES);
        wait_drained();

        queue_random_traffic(650);
        wait_drained();

        queue_random_traffic(650);
        wait_drained();

        quiet = 1'b1;
        queue_random_traffic(300);
        wait_drained();
        repeat (20) @(posedge aclk);

        if (expected_frames.size() != 0) begin
            $error("%0d expected results never arrived", expected_frames.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("tb_manchester_frame_decoder: PASS");
        end else begin
            $display("tb_manchester_frame_decoder: FAIL");
        end
        $finish;
    end

endmodule
